### hw/rtl/polyphase_interpolator_assert.svh
// Assertion macros for the polyphase interpolator checker.
// No dependencies; included by the checker file.
`ifndef POLYPHASE_INTERPOLATOR_ASSERT_SVH
`define POLYPHASE_INTERPOLATOR_ASSERT_SVH

// same-cycle implication
`define PPI_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PPI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/ppi_pkg.sv
// Shared types and constants for the polyphase interpolator.
// No dependencies.
package ppi_pkg;

   localparam int MAX_INTERP_DEF      = 16;
   localparam int MAX_TAPS_DEF        = 32;
   localparam int SAMPLE_BITS_DEF     = 16;

   localparam int FACTOR_W            = 5;
   localparam int TAPS_W              = 6;
   localparam int COEF_IDX_W          = 9;
   localparam int PHASE_W             = 4;
   localparam int CSR_IDX_W           = 2;
   localparam int CSR_DATA_W          = 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FACTOR = 2'd0,
      CSR_TAPS   = 2'd1
   } csr_reg_type;

   typedef enum logic {
      MODE_SAMPLE = 1'b0,
      MODE_COEF   = 1'b1
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_RUN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic push;
      logic coef_wr;
      logic setup;
      logic issue;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic last_tap;
      logic last_phase;
      logic busy;
      logic out_free;
   } status_type;

endpackage

### hw/rtl/ppi_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ppi_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/ppi_datapath.sv
// Datapath: config registers, coefficient and history RAMs, address counters,
// shared MAC pipeline and output register. Uses ppi_pkg and ppi_ram.
module ppi_datapath #(
   parameter int MAX_INTERP  = ppi_pkg::MAX_INTERP_DEF,
   parameter int MAX_TAPS    = ppi_pkg::MAX_TAPS_DEF,
   parameter int SAMPLE_BITS = ppi_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ppi_pkg::cmd_type                     cmd,
   output ppi_pkg::status_type                  status,
   input  logic                                 csr_wr,
   input  logic [ppi_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ppi_pkg::CSR_DATA_W-1:0]       csr_data,
   input  logic signed [SAMPLE_BITS-1:0]        sample,
   input  logic [ppi_pkg::COEF_IDX_W-1:0]       coeff_index,
   input  logic signed [SAMPLE_BITS-1:0]        coeff_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]        out_sample,
   output logic [ppi_pkg::PHASE_W-1:0]          phase,
   output logic                                 last_of_run
);

   localparam int COEF_DEPTH = MAX_INTERP * MAX_TAPS;
   localparam int CAW        = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
   localparam int HAW        = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int PHW        = (MAX_INTERP > 1) ? $clog2(MAX_INTERP) : 1;
   localparam int TEW        = $clog2(MAX_TAPS + 1);
   localparam int PRODW      = 2 * SAMPLE_BITS;
   localparam int ACW_RAW    = PRODW + TEW;
   localparam bit CLAMP      = (ACW_RAW >= 63);
   localparam int ACW        = CLAMP ? 64 : ACW_RAW;

   localparam logic signed [ACW-1:0] OUT_MAX =
      ACW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [ACW-1:0] OUT_MIN = -OUT_MAX - ACW'(1);

   logic [ppi_pkg::FACTOR_W-1:0] factor_ff;
   logic [ppi_pkg::TAPS_W-1:0]   taps_ff;
   logic [HAW-1:0]               ptr_ff;
   logic [HAW-1:0]               ptr_in;
   logic [MAX_TAPS-1:0]          hist_vld_ff;
   logic [PHW-1:0]               phase_ff;
   logic [HAW-1:0]               tap_ff;
   logic [CAW-1:0]               caddr_ff;
   logic [HAW-1:0]               hptr_ff;
   logic [HAW-1:0]               hptr_in;
   logic                         rd_vld_ff;
   logic                         hv_ff;
   logic                         mul_vld_ff;
   logic signed [PRODW-1:0]      prod_ff;
   logic signed [ACW-1:0]        acc_ff;
   logic signed [ACW-1:0]        acc_in;
   logic signed [ACW-1:0]        shifted;
   logic signed [SAMPLE_BITS-1:0] out_in;
   logic                         rsp_vld_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_data_ff;
   logic [ppi_pkg::PHASE_W-1:0]  rsp_phase_ff;
   logic                         rsp_last_ff;

   logic [7:0]                   fac_raw;
   logic [7:0]                   fac_eff;
   logic [8:0]                   tap_raw;
   logic [8:0]                   tap_eff;
   logic                         coef_in_range;
   logic signed [SAMPLE_BITS-1:0] coef_rd;
   logic signed [SAMPLE_BITS-1:0] hist_rd;
   logic signed [SAMPLE_BITS-1:0] hist_op;

   // clamp configured values into the supported range
   always_comb begin
      fac_raw = 8'(factor_ff);
      tap_raw = 9'(taps_ff);
      if (fac_raw == 8'd0) begin
         fac_eff = 8'd1;
      end else if (fac_raw > 8'(MAX_INTERP)) begin
         fac_eff = 8'(MAX_INTERP);
      end else begin
         fac_eff = fac_raw;
      end
      if (tap_raw == 9'd0) begin
         tap_eff = 9'd1;
      end else if (tap_raw > 9'(MAX_TAPS)) begin
         tap_eff = 9'(MAX_TAPS);
      end else begin
         tap_eff = tap_raw;
      end
   end

   assign ptr_in  = (ptr_ff == '0) ? HAW'(MAX_TAPS - 1) : ptr_ff - HAW'(1);
   assign hptr_in = (hptr_ff == HAW'(MAX_TAPS - 1)) ? '0 : hptr_ff + HAW'(1);
   assign coef_in_range = (32'(coeff_index) < 32'(COEF_DEPTH));

   ppi_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (COEF_DEPTH)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (cmd.coef_wr && coef_in_range),
      .wr_addr (CAW'(coeff_index)),
      .wr_data (coeff_value),
      .rd_en   (cmd.issue),
      .rd_addr (caddr_ff),
      .rd_data (coef_rd)
   );

   ppi_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_TAPS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (ptr_in),
      .wr_data (sample),
      .rd_en   (cmd.issue),
      .rd_addr (hptr_ff),
      .rd_data (hist_rd)
   );

   // never-written history entries read as zero
   assign hist_op = hv_ff ? hist_rd : '0;

   generate
      if (CLAMP) begin : g_clamp
         localparam logic signed [ACW:0] ACC_LIM =
            (ACW + 1)'(64'sh3FFF_FFFF_FFFF_FFFF);
         logic signed [ACW:0] wide_sum;
         always_comb begin
            wide_sum = (ACW + 1)'(acc_ff) + (ACW + 1)'(prod_ff);
            if (wide_sum > ACC_LIM) begin
               acc_in = ACW'(ACC_LIM);
            end else if (wide_sum < -ACC_LIM) begin
               acc_in = ACW'(-ACC_LIM);
            end else begin
               acc_in = ACW'(wide_sum);
            end
         end
      end else begin : g_plain
         assign acc_in = acc_ff + ACW'(prod_ff);
      end
   endgenerate

   // floor shift back to Q1.15, then saturate
   always_comb begin
      shifted = acc_ff >>> (SAMPLE_BITS - 1);
      if (shifted > OUT_MAX) begin
         out_in = SAMPLE_BITS'(OUT_MAX);
      end else if (shifted < OUT_MIN) begin
         out_in = SAMPLE_BITS'(OUT_MIN);
      end else begin
         out_in = SAMPLE_BITS'(shifted);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff   <= ppi_pkg::FACTOR_W'(1);
         taps_ff     <= ppi_pkg::TAPS_W'(1);
         ptr_ff      <= '0;
         hist_vld_ff <= '0;
         rd_vld_ff   <= 1'b0;
         mul_vld_ff  <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         if (csr_wr) begin
            case (csr_index)
               ppi_pkg::CSR_FACTOR: factor_ff <= csr_data[ppi_pkg::FACTOR_W-1:0];
               ppi_pkg::CSR_TAPS:   taps_ff   <= csr_data[ppi_pkg::TAPS_W-1:0];
               default: ;
            endcase
         end
         if (cmd.push) begin
            ptr_ff              <= ptr_in;
            hist_vld_ff[ptr_in] <= 1'b1;
         end
         rd_vld_ff  <= cmd.issue;
         mul_vld_ff <= rd_vld_ff;
         if (cmd.emit) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         phase_ff <= '0;
      end else if (cmd.emit) begin
         phase_ff <= phase_ff + PHW'(1);
      end
      if (cmd.setup) begin
         tap_ff   <= '0;
         caddr_ff <= CAW'(phase_ff);
         hptr_ff  <= ptr_ff;
         acc_ff   <= '0;
      end else begin
         if (cmd.issue) begin
            tap_ff   <= tap_ff + HAW'(1);
            caddr_ff <= caddr_ff + CAW'(fac_eff);
            hptr_ff  <= hptr_in;
            hv_ff    <= hist_vld_ff[hptr_ff];
         end
         if (mul_vld_ff) begin
            acc_ff <= acc_in;
         end
      end
      if (rd_vld_ff) begin
         prod_ff <= coef_rd * hist_op;
      end
      if (cmd.emit) begin
         rsp_data_ff  <= out_in;
         rsp_phase_ff <= ppi_pkg::PHASE_W'(phase_ff);
         rsp_last_ff  <= status.last_phase;
      end
   end

   assign status.last_tap   = (9'(tap_ff) == tap_eff - 9'd1);
   assign status.last_phase = (8'(phase_ff) == fac_eff - 8'd1);
   assign status.busy       = rd_vld_ff || mul_vld_ff;
   assign status.out_free   = !rsp_vld_ff || rsp_ready;

   assign rsp_valid   = rsp_vld_ff;
   assign out_sample  = rsp_data_ff;
   assign phase       = rsp_phase_ff;
   assign last_of_run = rsp_last_ff;

endmodule

### hw/rtl/ppi_ctrl.sv
// Controller state machine: sequences input transfers, per-phase MAC runs
// and result hand-off. Uses ppi_pkg.
module ppi_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_mode,
   output logic                req_ready,
   input  ppi_pkg::status_type status,
   output ppi_pkg::cmd_type    cmd
);

   ppi_pkg::state_type state_ff;
   ppi_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ppi_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ppi_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_mode == ppi_pkg::MODE_COEF) begin
                  cmd.coef_wr = 1'b1;
               end else begin
                  cmd.push = 1'b1;
                  state_in = ppi_pkg::ST_SETUP;
               end
            end
         end
         ppi_pkg::ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ppi_pkg::ST_RUN;
         end
         ppi_pkg::ST_RUN: begin
            cmd.issue = 1'b1;
            if (status.last_tap) begin
               state_in = ppi_pkg::ST_DRAIN;
            end
         end
         ppi_pkg::ST_DRAIN: begin
            if (!status.busy) begin
               state_in = ppi_pkg::ST_EMIT;
            end
         end
         ppi_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = status.last_phase ? ppi_pkg::ST_IDLE : ppi_pkg::ST_SETUP;
            end
         end
         default: begin
            state_in = ppi_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### hw/rtl/polyphase_interpolator.sv
// Polyphase interpolating FIR, top level: stream ports, controller, datapath.
// Uses ppi_pkg, ppi_ctrl, ppi_datapath (and ppi_ram below it).
//
// A coefficient write (tuser = 1) gives no result. A sample
// (tuser = 0) is pushed into a ring of the last MAX_TAPS samples, and then
// interp_factor results follow, phases 0 up to factor-1, the last with tlast.
// One shared multiply-accumulate pipeline does every tap, one per cycle; input
// is accepted again once the last result is in the output register. Config
// writes are always ready and must come while the block is idle.
module polyphase_interpolator #(
   parameter int MAX_INTERP  = ppi_pkg::MAX_INTERP_DEF,
   parameter int MAX_TAPS    = ppi_pkg::MAX_TAPS_DEF,
   parameter int SAMPLE_BITS = ppi_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // sample, coeff_index, coeff_value, zero pad
   input  logic [((2 * SAMPLE_BITS + ppi_pkg::COEF_IDX_W + 7) / 8) * 8 - 1:0] req_tdata,
   // mode
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // out_sample, phase, zero pad
   output logic [((SAMPLE_BITS + ppi_pkg::PHASE_W + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic                                 rsp_tlast,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ppi_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ppi_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int RSP_W  = ((SAMPLE_BITS + ppi_pkg::PHASE_W + 7) / 8) * 8;
   localparam int IDX_LO = SAMPLE_BITS;
   localparam int VAL_LO = SAMPLE_BITS + ppi_pkg::COEF_IDX_W;

   ppi_pkg::cmd_type              cmd;
   ppi_pkg::status_type           status;
   logic signed [SAMPLE_BITS-1:0] out_sample;
   logic [ppi_pkg::PHASE_W-1:0]   phase;

   assign csr_ready = 1'b1;

   ppi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_mode  (req_tuser),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   ppi_datapath #(
      .MAX_INTERP  (MAX_INTERP),
      .MAX_TAPS    (MAX_TAPS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .csr_wr      (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .sample      (req_tdata[SAMPLE_BITS-1:0]),
      .coeff_index (req_tdata[IDX_LO +: ppi_pkg::COEF_IDX_W]),
      .coeff_value (req_tdata[VAL_LO +: SAMPLE_BITS]),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .out_sample  (out_sample),
      .phase       (phase),
      .last_of_run (rsp_tlast)
   );

   assign rsp_tdata = RSP_W'({phase, out_sample});

endmodule

### hw/rtl/ppi_checker.sv
// Port-level checker for the polyphase interpolator, bound to the top level.
// Uses ppi_pkg and polyphase_interpolator_assert.svh.
`include "polyphase_interpolator_assert.svh"

module ppi_checker #(
   parameter int RSP_W = 24
) (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             req_tuser,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata,
   input logic             rsp_tlast
);

   `PPI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "result changed while stalled")
   `PPI_ASSERT_NEXT(a_reset_state, clock, 1'b0, reset, req_tready && !rsp_tvalid, "not idle after reset")
   `PPI_ASSERT_NEXT(a_sample_busy, clock, reset, req_tvalid && req_tready && (req_tuser == ppi_pkg::MODE_SAMPLE), !req_tready, "input taken during a run")
   `PPI_ASSERT_IMPL(a_run_open, clock, reset, rsp_tvalid && !rsp_tlast, !req_tready, "input ready before run finished")

endmodule

bind polyphase_interpolator ppi_checker #(
   .RSP_W (RSP_W)
) u_ppi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

### bench/polyphase_interpolator_tb.sv
// Self-checking testbench for the polyphase interpolator: stream stimulus, CSR setup,
// and a local polyphase FIR predictor checked against every result transfer.
// Depends on ppi_pkg and polyphase_interpolator.
module polyphase_interpolator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SB          = ppi_pkg::SAMPLE_BITS_DEF;
   localparam int REQ_W       = ((2 * SB + ppi_pkg::COEF_IDX_W + 7) / 8) * 8;
   localparam int RSP_W       = ((SB + ppi_pkg::PHASE_W + 7) / 8) * 8;
   localparam int TABLE_DEPTH = ppi_pkg::MAX_INTERP_DEF * ppi_pkg::MAX_TAPS_DEF;
   localparam int LOAD_DEPTH  = 64;
   localparam int SETTLE_CYC  = 16;
   localparam int END_CYC     = 64;

   typedef struct {
      logic signed [SB-1:0]        value;
      logic [ppi_pkg::PHASE_W-1:0] phase;
      logic                        last;
   } interp_out_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [REQ_W-1:0]               req_tdata = '0;
   logic                           req_tuser = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [RSP_W-1:0]               rsp_tdata;
   logic                           rsp_tlast;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [ppi_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [ppi_pkg::CSR_DATA_W-1:0] csr_data = '0;

   // predictor state
   logic [ppi_pkg::FACTOR_W-1:0]   factor_reg;
   logic [ppi_pkg::TAPS_W-1:0]     taps_reg;
   logic signed [SB-1:0]           coef_table [TABLE_DEPTH];
   logic signed [SB-1:0]           sample_ring [ppi_pkg::MAX_TAPS_DEF];
   logic [$clog2(ppi_pkg::MAX_TAPS_DEF)-1:0] ring_head;
   interp_out_type                 pending_outputs [$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_req       = 0;
   int hold_left      = 0;
   int errors         = 0;
   int n_samples      = 0;
   int n_coefs        = 0;
   int n_results      = 0;
   int n_settings     = 0;

   always #4 clock = ~clock;

   polyphase_interpolator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   function automatic void filter_sample(logic signed [SB-1:0] x);
      int             fe;
      int             te;
      longint         acc;
      longint         y;
      interp_out_type o;
      fe = factor_reg;
      if (fe == 0) fe = 1;
      if (fe > ppi_pkg::MAX_INTERP_DEF) fe = ppi_pkg::MAX_INTERP_DEF;
      te = taps_reg;
      if (te == 0) te = 1;
      if (te > ppi_pkg::MAX_TAPS_DEF) te = ppi_pkg::MAX_TAPS_DEF;
      ring_head = ring_head - 1'b1;
      sample_ring[ring_head] = x;
      for (int ph = 0; ph < fe; ph++) begin
         acc = 0;
         for (int n = 0; n < te; n++) begin
            acc += longint'(coef_table[n * fe + ph]) *
                   longint'(sample_ring[(ring_head + n) % ppi_pkg::MAX_TAPS_DEF]);
         end
         y = acc >>> (SB - 1);
         if (y > 32767) y = 32767;
         if (y < -32768) y = -32768;
         o.value = y[SB-1:0];
         o.phase = ph[ppi_pkg::PHASE_W-1:0];
         o.last  = (ph == fe - 1);
         pending_outputs.push_back(o);
      end
   endfunction

   task automatic send_item(ppi_pkg::mode_type mode, logic signed [SB-1:0] smp,
                            logic [ppi_pkg::COEF_IDX_W-1:0] idx,
                            logic signed [SB-1:0] val);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= REQ_W'({val, idx, smp});
      do @(posedge clock); while (!req_tready);
      if (mode == ppi_pkg::MODE_COEF) begin
         coef_table[idx] = val;
         n_coefs++;
      end else begin
         filter_sample(smp);
         n_samples++;
      end
   endtask

   task automatic send_sample(logic signed [SB-1:0] x);
      send_item(ppi_pkg::MODE_SAMPLE, x, ppi_pkg::COEF_IDX_W'($urandom), SB'($urandom));
   endtask

   task automatic send_coef(logic [ppi_pkg::COEF_IDX_W-1:0] idx, logic signed [SB-1:0] val);
      send_item(ppi_pkg::MODE_COEF, SB'($urandom), idx, val);
   endtask

   task automatic send_random_item();
      logic signed [SB-1:0] v;
      if ($urandom_range(0, 3) == 0) begin
         v = ($urandom_range(0, 1) == 0) ? SB'($urandom) :
             SB'(int'($urandom_range(0, 8191)) - 4096);
         send_coef(ppi_pkg::COEF_IDX_W'($urandom_range(0, TABLE_DEPTH - 1)), v);
      end else begin
         case ($urandom_range(0, 15))
            0:       send_sample(16'sh7fff);
            1:       send_sample(16'sh8000);
            default: send_sample(SB'($urandom));
         endcase
      end
   endtask

   task automatic stop_sending();
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_idle(int extra);
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_reg(ppi_pkg::csr_reg_type idx, int v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= ppi_pkg::CSR_DATA_W'(v);
      do @(posedge clock); while (!csr_ready);
      if (idx == ppi_pkg::CSR_FACTOR) factor_reg = v[ppi_pkg::FACTOR_W-1:0];
      else taps_reg = v[ppi_pkg::TAPS_W-1:0];
   endtask

   task automatic set_config(int f, int t);
      write_reg(ppi_pkg::CSR_FACTOR, f);
      write_reg(ppi_pkg::CSR_TAPS, t);
      csr_valid <= 1'b0;
      n_settings++;
   endtask

   task automatic check_output();
      interp_out_type e;
      if (pending_outputs.size() == 0) begin
         $error("unexpected result transfer: out_sample %0d phase %0d",
                $signed(rsp_tdata[SB-1:0]), rsp_tdata[SB +: ppi_pkg::PHASE_W]);
         errors++;
      end else begin
         e = pending_outputs.pop_front();
         n_results++;
         if (rsp_tdata[SB-1:0] !== e.value) begin
            $error("out_sample: expected %0d, got %0d", e.value, $signed(rsp_tdata[SB-1:0]));
            errors++;
         end
         if (rsp_tdata[SB +: ppi_pkg::PHASE_W] !== e.phase) begin
            $error("phase: expected %0d, got %0d", e.phase,
                   rsp_tdata[SB +: ppi_pkg::PHASE_W]);
            errors++;
         end
         if (rsp_tlast !== e.last) begin
            $error("last_of_run: expected %0d, got %0d", e.last, rsp_tlast);
            errors++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_output();
      if (hold_req > 0) begin
         hold_left = hold_req;
         hold_req  = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // coefficient table is undefined after reset; every setting below reads
   // only the first LOAD_DEPTH entries, so fill those first
   task automatic test_table_load();
      set_config(1, 1);
      for (int i = 0; i < LOAD_DEPTH; i++)
         send_coef(ppi_pkg::COEF_IDX_W'(i), ($urandom_range(0, 3) == 0) ? SB'($urandom) :
                   SB'(int'($urandom_range(0, 8191)) - 4096));
      stop_sending();
      wait_idle(SETTLE_CYC);
   endtask

   task automatic test_extremes();
      set_config(1, 1);
      send_coef(ppi_pkg::COEF_IDX_W'(0), 16'sh7fff);
      send_sample(16'sh7fff);
      send_sample(16'sh8000);
      send_sample(16'sh0000);
      send_sample(16'shffff);
      send_coef(ppi_pkg::COEF_IDX_W'(0), 16'sh8000);
      send_sample(16'sh8000);   // positive saturation
      send_sample(16'sh7fff);
      stop_sending();
      wait_idle(SETTLE_CYC);
      set_config(1, 2);
      send_coef(ppi_pkg::COEF_IDX_W'(1), 16'sh8000);
      send_sample(16'sh7fff);
      send_sample(16'sh7fff);   // negative saturation
      stop_sending();
      wait_idle(SETTLE_CYC);
      set_config(0, 0);         // zero acts as one
      send_sample(SB'($urandom));
      send_sample(SB'($urandom));
      stop_sending();
      wait_idle(SETTLE_CYC);
      set_config(31, 4);        // factor clamps to the maximum
      send_coef(ppi_pkg::COEF_IDX_W'(LOAD_DEPTH - 1), 16'sh7fff);
      send_sample(16'sh7fff);
      send_coef(ppi_pkg::COEF_IDX_W'(LOAD_DEPTH - 1), 16'sh8000);
      send_sample(16'sh8000);
      stop_sending();
      wait_idle(SETTLE_CYC);
      set_config(1, 63);        // taps clamp to the maximum
      send_coef(ppi_pkg::COEF_IDX_W'(ppi_pkg::MAX_TAPS_DEF - 1), 16'sh7fff);
      send_sample(16'sh7fff);
      send_coef(ppi_pkg::COEF_IDX_W'(ppi_pkg::MAX_TAPS_DEF - 1), 16'sh8000);
      send_sample(16'sh8000);
      stop_sending();
      wait_idle(SETTLE_CYC);
   endtask

   task automatic test_random_phase(int f, int t, int count, int s_idle, int r_stall);
      set_config(f, t);
      send_idle_pct  = s_idle;
      recv_stall_pct = r_stall;
      for (int i = 0; i < count; i++) send_random_item();
      stop_sending();
      wait_idle(SETTLE_CYC);
   endtask

   task automatic test_backpressure();
      set_config(4, 2);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_req = 400;
      for (int i = 0; i < 24; i++) send_random_item();
      stop_sending();
      wait_idle(SETTLE_CYC);
   endtask

   initial begin
      factor_reg = 1;
      taps_reg   = 1;
      ring_head  = '0;
      for (int i = 0; i < ppi_pkg::MAX_TAPS_DEF; i++) sample_ring[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_table_load();
      test_extremes();
      test_random_phase(4, 8, 40, 0, 0);
      test_random_phase(2, 3, 40, 47, 0);
      test_random_phase(8, 5, 40, 0, 47);
      test_random_phase(3, 16, 40, 30, 30);
      test_random_phase(1, 32, 20, 30, 30);
      test_random_phase(16, 4, 12, 30, 30);
      test_random_phase(16, 1, 16, 0, 0);
      test_backpressure();
      wait_idle(END_CYC);
      if (pending_outputs.size() != 0) begin
         $error("%0d expected results never arrived", pending_outputs.size());
         errors++;
      end
      $display("run: %0d samples, %0d coefficient writes, %0d results checked",
               n_samples, n_coefs, n_results);
      $display("run: %0d register settings, idle/stall mixes and one long output hold",
               n_settings);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("tb: failure");
      $finish;
   end

endmodule
